>>> rtl/core/bmhq_pkg.sv
package bmhq_pkg;

    localparam int DEPTH_DEF     = 256;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int OUT_KEY_W     = 32;
    localparam int CNT_W         = 9;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_EXTRACT = 2'd1,
        REQ_PEEK    = 2'd2,
        REQ_NOP     = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    // command broadcast from the top level to every slot
    typedef enum logic [1:0] {
        CMD_IDLE   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_SHIFT  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        FSM_IDLE  = 2'd0,
        FSM_SHIFT = 2'd1,
        FSM_OUT   = 2'd2
    } fsm_t;

endpackage

>>> rtl/core/binary_min_heap_queue.sv
// channel | ports                             | direction
// s_      | s_valid s_ready s_req_type s_key_in | in
// m_      | m_valid m_ready m_key_out m_status m_count | out
//
// each item goes through accept in idle, then the shift state, then the result state held until m_ready
// the slot row is a sorted chain; insert and extract each take effect in the shift state
// slot row orders keys exactly as the heap's extraction order (same minimum)
// synchronous active-low reset empties the row
// m_valid holds with stable payload until m_ready; s_ready is low while busy
module binary_min_heap_queue #(
    parameter int DEPTH     = bmhq_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_req_type,
    input  logic [KEY_WIDTH-1:0]           s_key_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bmhq_pkg::OUT_KEY_W-1:0] m_key_out,
    output logic [1:0]                     m_status,
    output logic [bmhq_pkg::CNT_W-1:0]     m_count
);

    localparam int CW = $clog2(DEPTH + 1);

    bmhq_pkg::fsm_t       state_reg, state_next;
    bmhq_pkg::cmd_t       cmd;
    logic [KEY_WIDTH-1:0] nkey_reg;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [1:0]           req_reg;
    logic [bmhq_pkg::OUT_KEY_W-1:0] okey_reg, okey_next;
    logic [1:0]           ost_reg, ost_next;

    logic                 sv   [DEPTH];
    logic [KEY_WIDTH-1:0] sk   [DEPTH];
    logic                 stk  [DEPTH];

    // chain of slots: each sees its left neighbor for insert and right for extract
    for (genvar i = 0; i < DEPTH; i++) begin : g_slot
        logic                 lv, lt, rv;
        logic [KEY_WIDTH-1:0] lk, rk;
        if (i == 0) begin : g_first
            assign lv = 1'b0;
            assign lk = '0;
            assign lt = 1'b0;
        end else begin : g_mid
            assign lv = sv[i-1];
            assign lk = sk[i-1];
            assign lt = stk[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign rv = 1'b0;
            assign rk = '0;
        end else begin : g_body
            assign rv = sv[i+1];
            assign rk = sk[i+1];
        end
        bmhq_slot #(.KEY_WIDTH(KEY_WIDTH)) u_slot (
            .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .new_key(nkey_reg),
            .left_valid(lv), .left_key(lk), .left_takes(lt),
            .right_valid(rv), .right_key(rk),
            .valid(sv[i]), .key(sk[i]), .takes(stk[i])
        );
    end

    logic accept;
    logic full, empty;
    logic [bmhq_pkg::OUT_KEY_W-1:0] root_ext;

    assign accept = s_valid && s_ready;
    assign full   = (cnt_reg == CW'(DEPTH));
    assign empty  = (cnt_reg == '0);
    assign root_ext = bmhq_pkg::OUT_KEY_W'(sk[0]);

    // next-state logic
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bmhq_pkg::FSM_IDLE:  if (accept) state_next = bmhq_pkg::FSM_SHIFT;
            bmhq_pkg::FSM_SHIFT: state_next = bmhq_pkg::FSM_OUT;
            bmhq_pkg::FSM_OUT:   if (m_ready) state_next = bmhq_pkg::FSM_IDLE;
            default:             state_next = bmhq_pkg::FSM_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        cmd       = bmhq_pkg::CMD_IDLE;
        cnt_next  = cnt_reg;
        okey_next = okey_reg;
        ost_next  = ost_reg;
        s_ready   = (state_reg == bmhq_pkg::FSM_IDLE);
        m_valid   = (state_reg == bmhq_pkg::FSM_OUT);
        if (state_reg == bmhq_pkg::FSM_SHIFT) begin
            okey_next = '0;
            ost_next  = bmhq_pkg::ST_OK;
            case (req_reg)
                bmhq_pkg::REQ_INSERT: begin
                    if (full) begin
                        ost_next = bmhq_pkg::ST_FULL;
                    end else begin
                        cmd      = bmhq_pkg::CMD_INSERT;
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
                bmhq_pkg::REQ_EXTRACT: begin
                    if (empty) begin
                        ost_next = bmhq_pkg::ST_EMPTY;
                    end else begin
                        cmd       = bmhq_pkg::CMD_SHIFT;
                        okey_next = root_ext;
                        cnt_next  = cnt_reg - CW'(1);
                    end
                end
                bmhq_pkg::REQ_PEEK: begin
                    if (empty) ost_next = bmhq_pkg::ST_EMPTY;
                    else okey_next = root_ext;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bmhq_pkg::FSM_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        if (accept) begin
            req_reg  <= s_req_type;
            nkey_reg <= s_key_in;
        end
        okey_reg <= okey_next;
        ost_reg  <= ost_next;
    end

    assign m_key_out = okey_reg;
    assign m_status  = ost_reg;
    assign m_count   = bmhq_pkg::CNT_W'(cnt_reg);

    // checks
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH)) else $error("count overflow");
    a_root_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) |-> sv[0]) else $error("root empty while count nonzero");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != bmhq_pkg::FSM_IDLE) |-> !s_ready) else $error("ready while busy");
    a_out_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> ##1 m_valid) else $error("result missing");

endmodule

>>> rtl/core/bmhq_slot.sv
// one sorted slot: keeps the row ordered ascending from slot 0
module bmhq_slot #(
    parameter int KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bmhq_pkg::cmd_t       cmd,
    input  logic [KEY_WIDTH-1:0] new_key,
    input  logic                 left_valid,
    input  logic [KEY_WIDTH-1:0] left_key,
    input  logic                 left_takes,
    input  logic                 right_valid,
    input  logic [KEY_WIDTH-1:0] right_key,
    output logic                 valid,
    output logic [KEY_WIDTH-1:0] key,
    output logic                 takes
);

    logic                 valid_reg, valid_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;

    // new key belongs here or before: slot empty or new key strictly smaller than held key (ties stay behind)
    assign takes = !valid_reg || (new_key < key_reg);

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        case (cmd)
            bmhq_pkg::CMD_INSERT: begin
                if (left_takes) begin
                    valid_next = left_valid;
                    key_next   = left_key;
                end else if (takes) begin
                    valid_next = 1'b1;
                    key_next   = new_key;
                end
            end
            bmhq_pkg::CMD_SHIFT: begin
                valid_next = right_valid;
                key_next   = right_key;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        key_reg <= key_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;

endmodule
